// ----- design/assert_macros.svh -----
// Assertion macros used by the port-level checker of the spring table.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge, switched off while reset is low
`define SPR_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Property checked on every rising edge, reset included
`define SPR_ASSERT_ALL(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

// ----- design/spranim_pkg.sv -----
// Shared constants, types and helpers for the spring animation table.
// No dependencies; used by spranim_step, the top level and the checker.
package spranim_pkg;

  // Table geometry
  localparam int SLOTS  = 16;
  localparam int IDX_W  = $clog2(SLOTS);
  localparam int SLOT_W = 4;

  // Operation codes
  localparam logic [1:0] OP_SET   = 2'd0;
  localparam logic [1:0] OP_TICK  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_STIFFNESS = 2'd0;
  localparam logic [1:0] REG_DAMPING   = 2'd1;
  localparam logic [1:0] REG_SNAP      = 2'd2;

  // Reset values of the configuration registers
  localparam logic [15:0] STIFFNESS_RST = 16'd2880;
  localparam logic [13:0] DAMPING_RST   = 14'd320;
  localparam logic [15:0] SNAP_RST      = 16'd655;

  // Saturation limits of a signed Q16.16 word, held at 64 bits
  localparam logic signed [63:0] S32_MAX = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0] S32_MIN = 64'shFFFF_FFFF_8000_0000;

  // Tag that travels with a slot through the step pipeline
  typedef struct packed {
    logic              vld;
    logic [SLOT_W-1:0] slot;
    logic              last;
  } meta_t;

  // Clamp a wide signed value to signed 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    logic signed [31:0] r;
    if (x > S32_MAX) begin
      r = 32'sh7FFF_FFFF;
    end else if (x < S32_MIN) begin
      r = 32'sh8000_0000;
    end else begin
      r = $signed(x[31:0]);
    end
    return r;
  endfunction

endpackage

// ----- design/spranim_step.sv -----
// Eight-stage datapath that advances one slot by semi-implicit Euler.
// Depends on spranim_pkg (meta_t, sat32).
module spranim_step (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  spranim_pkg::meta_t        meta_i,
  input  logic signed [31:0]        pos_i,
  input  logic signed [31:0]        vel_i,
  input  logic signed [31:0]        tgt_i,
  input  logic [15:0]               stiffness_i,
  input  logic [13:0]               damping_i,
  input  logic [15:0]               snap_i,
  input  logic [15:0]               dt_i,
  output spranim_pkg::meta_t        meta_o,
  output logic signed [31:0]        pos_o,
  output logic signed [31:0]        vel_o,
  output logic                      busy_o
);

  localparam int STAGES = 8;

  spranim_pkg::meta_t meta_q [STAGES];

  // stage 1: offset from target
  logic signed [32:0] off_d, off_q;
  logic signed [31:0] pos1_q, vel1_q, tgt1_q;
  // stage 2: stiffness and damping products
  logic signed [49:0] mk_d, mk_q;
  logic signed [46:0] md_d, md_q;
  logic signed [31:0] pos2_q, vel2_q, tgt2_q;
  // stage 3: force
  logic signed [50:0] raw_d;
  logic signed [63:0] raw_sh;
  logic signed [31:0] force_d, force_q;
  logic signed [31:0] pos3_q, vel3_q, tgt3_q;
  // stage 4: force times dt
  logic signed [48:0] fdt_d, fdt_q;
  logic signed [31:0] pos4_q, vel4_q, tgt4_q;
  // stage 5: new velocity
  logic signed [63:0] vsum;
  logic signed [31:0] vn_d, vn5_q;
  logic signed [31:0] pos5_q, tgt5_q;
  // stage 6: velocity times dt
  logic signed [48:0] vdt_d, vdt_q;
  logic signed [31:0] vn6_q, pos6_q, tgt6_q;
  // stage 7: new position
  logic signed [63:0] psum;
  logic signed [31:0] pn_d, pn7_q, vn7_q, tgt7_q;
  // stage 8: settle test
  logic signed [32:0] gap_d, thr, vn_w;
  logic               settle;
  logic signed [31:0] pos_d, vel_d, pos_q, vel_q;

  // Arithmetic of each stage
  always_comb begin
    off_d   = $signed({pos_i[31], pos_i}) - $signed({tgt_i[31], tgt_i});
    mk_d    = 50'($signed({1'b0, stiffness_i})) * 50'(off_q);
    md_d    = 47'($signed({1'b0, damping_i})) * 47'(vel1_q);
    raw_d   = -51'(mk_q) - 51'(md_q);
    raw_sh  = 64'(raw_d) >>> 4;
    force_d = spranim_pkg::sat32(raw_sh);
    fdt_d   = 49'(force_q) * 49'($signed({1'b0, dt_i}));
    vsum    = 64'(fdt_q) >>> 16;
    vsum    = vsum + 64'(vel4_q);
    vn_d    = spranim_pkg::sat32(vsum);
    vdt_d   = 49'(vn5_q) * 49'($signed({1'b0, dt_i}));
    psum    = 64'(vdt_q) >>> 16;
    psum    = psum + 64'(pos6_q);
    pn_d    = spranim_pkg::sat32(psum);
    gap_d   = 33'(pn7_q) - 33'(tgt7_q);
    thr     = $signed({17'b0, snap_i});
    vn_w    = 33'(vn7_q);
    settle  = (gap_d < thr) && (gap_d > -thr) && (vn_w < thr) && (vn_w > -thr);
    pos_d   = settle ? tgt7_q : pn7_q;
    vel_d   = settle ? 32'sd0 : vn7_q;
  end

  // Tag pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < STAGES; k++) meta_q[k] <= '0;
    end else begin
      meta_q[0] <= meta_i;
      for (int k = 1; k < STAGES; k++) meta_q[k] <= meta_q[k-1];
    end
  end

  // Data pipeline, no reset needed
  always_ff @(posedge clk_i) begin
    off_q   <= off_d;
    pos1_q  <= pos_i;   vel1_q <= vel_i;   tgt1_q <= tgt_i;
    mk_q    <= mk_d;    md_q   <= md_d;
    pos2_q  <= pos1_q;  vel2_q <= vel1_q;  tgt2_q <= tgt1_q;
    force_q <= force_d;
    pos3_q  <= pos2_q;  vel3_q <= vel2_q;  tgt3_q <= tgt2_q;
    fdt_q   <= fdt_d;
    pos4_q  <= pos3_q;  vel4_q <= vel3_q;  tgt4_q <= tgt3_q;
    vn5_q   <= vn_d;
    pos5_q  <= pos4_q;  tgt5_q <= tgt4_q;
    vdt_q   <= vdt_d;
    vn6_q   <= vn5_q;   pos6_q <= pos5_q;  tgt6_q <= tgt5_q;
    pn7_q   <= pn_d;
    vn7_q   <= vn6_q;   tgt7_q <= tgt6_q;
    pos_q   <= pos_d;
    vel_q   <= vel_d;
  end

  // Any slot still in flight
  always_comb begin
    busy_o = 1'b0;
    for (int k = 0; k < STAGES; k++) busy_o = busy_o | meta_q[k].vld;
  end

  assign meta_o = meta_q[STAGES-1];
  assign pos_o  = pos_q;
  assign vel_o  = vel_q;

endmodule

// ----- design/spring_animation_table_top.sv -----
// Set-target and clear finish as they are accepted; busy stays low after them.
// Tick: busy through a scan of all SLOTS slots, one slot a cycle, and a drain
// that ends once the read tag and the 8-stage step hold no valid slot. A valid
// slot gives its result, one per cycle, after the read registers and the step.
// Results leave on a strobe that cannot be stalled; register writes wait while
// busy. Reset clears valid bits and loads default registers, not the memories.
module spring_animation_table_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  // command side
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         opcode_i,
  input  logic [3:0]         slot_i,
  input  logic signed [31:0] target_value_i,
  input  logic [15:0]        time_step_i,
  // result side
  output logic               result_valid_o,
  output logic [3:0]         slot_out_o,
  output logic signed [31:0] position_out_o,
  output logic               last_o,
  // configuration side
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i
);

  localparam int IDX_W  = spranim_pkg::IDX_W;
  localparam int SLOTS  = spranim_pkg::SLOTS;
  localparam int SLOT_W = spranim_pkg::SLOT_W;

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DRAIN} state_e;

  state_e             state_q;
  logic [IDX_W-1:0]   idx_q;
  logic [15:0]        dt_q;
  logic [SLOTS-1:0]   valid_q;
  logic [15:0]        stiffness_q;
  logic [13:0]        damping_q;
  logic [15:0]        snap_q;

  // memories: {position, velocity} and target per slot
  logic [63:0]        state_mem [SLOTS];
  logic [31:0]        tgt_mem   [SLOTS];
  logic [63:0]        state_rd_q;
  logic [31:0]        tgt_rd_q;
  spranim_pkg::meta_t rd_meta_q;

  logic               accept;
  logic               set_acc;
  logic [IDX_W-1:0]   set_idx;
  logic               rd_en;
  logic               upper_any;
  spranim_pkg::meta_t issue_meta;
  spranim_pkg::meta_t out_meta;
  logic signed [31:0] out_pos, out_vel;
  logic               step_busy;

  assign accept  = start && !busy;
  assign set_idx = slot_i[IDX_W-1:0];
  assign set_acc = accept && (opcode_i == spranim_pkg::OP_SET) && (int'(slot_i) < SLOTS);
  assign rd_en   = (state_q == ST_SCAN) && valid_q[idx_q];

  // any valid slot above the one being scanned
  always_comb begin
    upper_any = 1'b0;
    for (int j = 0; j < SLOTS; j++) begin
      if (j > int'(idx_q)) upper_any = upper_any | valid_q[j];
    end
  end

  always_comb begin
    issue_meta.vld  = rd_en;
    issue_meta.slot = SLOT_W'(idx_q);
    issue_meta.last = !upper_any;
  end

  // Control: scan sequencer, valid bits, read tag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      idx_q     <= '0;
      dt_q      <= '0;
      valid_q   <= '0;
      rd_meta_q <= '0;
    end else begin
      rd_meta_q <= issue_meta;
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            if (opcode_i == spranim_pkg::OP_TICK) begin
              state_q <= ST_SCAN;
              idx_q   <= '0;
              dt_q    <= time_step_i;
            end else if (opcode_i == spranim_pkg::OP_CLEAR) begin
              valid_q <= '0;
            end else if (set_acc) begin
              valid_q[set_idx] <= 1'b1;
            end
          end
        end
        ST_SCAN: begin
          if (idx_q == IDX_W'(SLOTS - 1)) begin
            state_q <= ST_DRAIN;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        ST_DRAIN: begin
          if (!rd_meta_q.vld && !step_busy) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign busy = (state_q != ST_IDLE);

  // State memory: write back stepped slots, zero a newly used slot
  always_ff @(posedge clk_i) begin
    if (out_meta.vld) begin
      state_mem[out_meta.slot[IDX_W-1:0]] <= {out_pos, out_vel};
    end else if (set_acc && !valid_q[set_idx]) begin
      state_mem[set_idx] <= '0;
    end
    if (rd_en) state_rd_q <= state_mem[idx_q];
  end

  // Target memory
  always_ff @(posedge clk_i) begin
    if (set_acc) tgt_mem[set_idx] <= target_value_i;
    if (rd_en)   tgt_rd_q <= tgt_mem[idx_q];
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stiffness_q <= spranim_pkg::STIFFNESS_RST;
      damping_q   <= spranim_pkg::DAMPING_RST;
      snap_q      <= spranim_pkg::SNAP_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        spranim_pkg::REG_STIFFNESS: stiffness_q <= cfg_data_i;
        spranim_pkg::REG_DAMPING:   damping_q   <= cfg_data_i[13:0];
        spranim_pkg::REG_SNAP:      snap_q      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // registers only change while no tick is in flight
  assign cfg_ready_o = !busy;

  spranim_step u_step (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .meta_i      (rd_meta_q),
    .pos_i       ($signed(state_rd_q[63:32])),
    .vel_i       ($signed(state_rd_q[31:0])),
    .tgt_i       ($signed(tgt_rd_q)),
    .stiffness_i (stiffness_q),
    .damping_i   (damping_q),
    .snap_i      (snap_q),
    .dt_i        (dt_q),
    .meta_o      (out_meta),
    .pos_o       (out_pos),
    .vel_o       (out_vel),
    .busy_o      (step_busy)
  );

  // Result word straight from the last pipeline register
  assign result_valid_o = out_meta.vld;
  assign slot_out_o     = out_meta.slot;
  assign position_out_o = out_pos;
  assign last_o         = out_meta.last;

endmodule

// ----- design/spranim_checker.sv -----
// Port-level checks for the spring animation table, bound to the top level.
// Depends on spranim_pkg and assert_macros.svh.
`include "assert_macros.svh"

module spranim_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start,
  input logic               busy,
  input logic [1:0]         opcode_i,
  input logic               result_valid_o,
  input logic [3:0]         slot_out_o
);

  logic       acc_tick;
  logic       acc_other;
  logic       back_to_back;
  logic       prev_valid_q;
  logic [3:0] prev_slot_q;

  // accepted command words, split by kind
  assign acc_tick  = start && !busy && (opcode_i == spranim_pkg::OP_TICK);
  assign acc_other = start && !busy && (opcode_i != spranim_pkg::OP_TICK);

  // previous result word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_valid_q <= 1'b0;
      prev_slot_q  <= '0;
    end else begin
      prev_valid_q <= result_valid_o;
      prev_slot_q  <= slot_out_o;
    end
  end

  assign back_to_back = result_valid_o && prev_valid_q;

  // results only appear while a tick is in progress
  `SPR_ASSERT(a_result_in_tick, clk_i, rst_ni, result_valid_o |-> busy, "result outside a tick")

  // a tick always raises busy; other commands never do
  `SPR_ASSERT(a_tick_busy, clk_i, rst_ni, acc_tick |=> busy, "tick did not start")
  `SPR_ASSERT(a_other_idle, clk_i, rst_ni, acc_other |=> !busy, "non-tick raised busy")

  // back-to-back words of one tick come in ascending slot order
  `SPR_ASSERT(a_slot_order, clk_i, rst_ni, back_to_back |-> (slot_out_o > prev_slot_q), "slot order")

  // nothing moves once reset has been seen
  `SPR_ASSERT_ALL(a_reset_quiet, clk_i, !rst_ni |=> (!busy && !result_valid_o), "busy in reset")

endmodule

bind spring_animation_table_top spranim_checker u_spranim_checker (.*);

// ----- tb/spring_table_checker.sv -----
`timescale 1ns / 1ps
// Scoreboard for the spring animation table: watches command, config and result words.
// Keeps its own copy of the slot table and predicts every stepped-slot result.
// Depends on spranim_pkg for table size, opcodes, register indexes and reset values.
module spring_table_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  // command side
  input  logic               start_i,
  input  logic               busy_i,
  input  logic [1:0]         opcode_i,
  input  logic [3:0]         slot_i,
  input  logic signed [31:0] target_value_i,
  input  logic [15:0]        time_step_i,
  // result side
  input  logic               result_valid_i,
  input  logic [3:0]         slot_out_i,
  input  logic signed [31:0] position_out_i,
  input  logic               last_i,
  // config side
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  // status towards the top
  output int                 mismatches_o,
  output int                 outstanding_o,
  output int                 checked_o
);

  // One predicted result word of a tick
  typedef struct packed {
    logic [3:0]         slot;
    logic signed [31:0] position;
    logic               last;
  } stepped_word_t;

  stepped_word_t      stepped_q[$];

  // Model copy of the table and registers
  logic signed [31:0] position_tbl [spranim_pkg::SLOTS];
  logic signed [31:0] velocity_tbl [spranim_pkg::SLOTS];
  logic signed [31:0] target_tbl   [spranim_pkg::SLOTS];
  logic               live_tbl     [spranim_pkg::SLOTS];
  logic [15:0]        stiffness_r;
  logic [13:0]        damping_r;
  logic [15:0]        snap_r;
  int                 mismatches;
  int                 checked;

  // Clamp to the signed Q16.16 range
  function automatic logic signed [31:0] clamp_q16(input logic signed [63:0] x);
    if (x > 64'sh0000_0000_7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (x < 64'shFFFF_FFFF_8000_0000) return 32'sh8000_0000;
    return x[31:0];
  endfunction

  // Semi-implicit Euler step of one slot; returns the new position
  function automatic logic signed [31:0] advance_slot(input int i, input logic [15:0] dt);
    logic signed [63:0] pos, vel, tgt, pull, accel, dt_w, k_w, c_w, snap_w, gap;
    dt_w   = $signed({48'd0, dt});
    k_w    = $signed({48'd0, stiffness_r});
    c_w    = $signed({50'd0, damping_r});
    snap_w = $signed({48'd0, snap_r});
    pos    = position_tbl[i];
    vel    = velocity_tbl[i];
    tgt    = target_tbl[i];
    pull   = -(k_w * (pos - tgt)) - c_w * vel;
    accel  = clamp_q16(pull >>> 4);
    // velocity first, then position from the new velocity
    vel    = clamp_q16(vel + ((accel * dt_w) >>> 16));
    pos    = clamp_q16(pos + ((vel * dt_w) >>> 16));
    gap    = pos - tgt;
    // settle onto the target once close and slow
    if ((gap < 0 ? -gap : gap) < snap_w && (vel < 0 ? -vel : vel) < snap_w) begin
      pos = tgt;
      vel = 0;
    end
    position_tbl[i] = pos[31:0];
    velocity_tbl[i] = vel[31:0];
    return pos[31:0];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch_words
    int            last_live;
    stepped_word_t want;
    if (!rst_ni) begin
      stiffness_r = spranim_pkg::STIFFNESS_RST;
      damping_r   = spranim_pkg::DAMPING_RST;
      snap_r      = spranim_pkg::SNAP_RST;
      for (int i = 0; i < spranim_pkg::SLOTS; i++) begin
        position_tbl[i] = '0;
        velocity_tbl[i] = '0;
        target_tbl[i]   = '0;
        live_tbl[i]     = 1'b0;
      end
      stepped_q.delete();
      mismatches    = 0;
      checked       = 0;
      mismatches_o  <= 0;
      outstanding_o <= 0;
      checked_o     <= 0;
    end else begin
      // register write
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          spranim_pkg::REG_STIFFNESS: stiffness_r = cfg_data_i;
          spranim_pkg::REG_DAMPING:   damping_r   = cfg_data_i[13:0];
          spranim_pkg::REG_SNAP:      snap_r      = cfg_data_i;
          default: ;
        endcase
      end

      // result word against the oldest prediction
      if (result_valid_i) begin
        if (stepped_q.size() == 0) begin
          mismatches++;
          $display("%0t: result with none expected: slot %0d position %0d last %0b",
                   $time, slot_out_i, position_out_i, last_i);
        end else begin
          want = stepped_q.pop_front();
          checked++;
          if (slot_out_i !== want.slot) begin
            mismatches++;
            $display("%0t: slot_out expected %0d, got %0d", $time, want.slot, slot_out_i);
          end
          if (position_out_i !== want.position) begin
            mismatches++;
            $display("%0t: position_out of slot %0d expected %0d, got %0d",
                     $time, want.slot, want.position, position_out_i);
          end
          if (last_i !== want.last) begin
            mismatches++;
            $display("%0t: last of slot %0d expected %0b, got %0b",
                     $time, want.slot, want.last, last_i);
          end
        end
      end

      // accepted command word
      if (start_i && !busy_i) begin
        case (opcode_i)
          spranim_pkg::OP_SET: begin
            // a fresh slot starts at rest; a live one keeps position and velocity
            if (!live_tbl[slot_i]) begin
              position_tbl[slot_i] = '0;
              velocity_tbl[slot_i] = '0;
            end
            target_tbl[slot_i] = target_value_i;
            live_tbl[slot_i]   = 1'b1;
          end
          spranim_pkg::OP_TICK: begin
            last_live = -1;
            for (int i = 0; i < spranim_pkg::SLOTS; i++) begin
              if (live_tbl[i]) last_live = i;
            end
            for (int i = 0; i < spranim_pkg::SLOTS; i++) begin
              if (live_tbl[i]) begin
                want.slot     = 4'(i);
                want.position = advance_slot(i, time_step_i);
                want.last     = (i == last_live);
                stepped_q.push_back(want);
              end
            end
          end
          spranim_pkg::OP_CLEAR: begin
            for (int i = 0; i < spranim_pkg::SLOTS; i++) begin
              position_tbl[i] = '0;
              velocity_tbl[i] = '0;
              target_tbl[i]   = '0;
              live_tbl[i]     = 1'b0;
            end
          end
          default: ;
        endcase
      end

      mismatches_o  <= mismatches;
      outstanding_o <= stepped_q.size();
      checked_o     <= checked;
    end
  end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// Top of the spring animation table testbench: clock, reset, stimulus and verdict.
// Depends on spranim_pkg, spring_animation_table_top and spring_table_checker.
module testbench;

  localparam int         CYCLE_LIMIT     = 200000;
  localparam int         SETTLE_CYCLES   = 32;
  localparam int         PHASES          = 8;
  localparam int         WORDS_PER_PHASE = 56;
  localparam logic [1:0] OP_UNUSED       = 2'd3;

  logic               clk          = 1'b0;
  logic               rst_n        = 1'b0;
  logic               start        = 1'b0;
  logic               busy;
  logic [1:0]         opcode       = spranim_pkg::OP_SET;
  logic [3:0]         slot         = '0;
  logic signed [31:0] target_value = '0;
  logic [15:0]        time_step    = '0;
  logic               result_valid;
  logic [3:0]         slot_out;
  logic signed [31:0] position_out;
  logic               last;
  logic               cfg_valid    = 1'b0;
  logic               cfg_ready;
  logic [1:0]         cfg_index    = spranim_pkg::REG_STIFFNESS;
  logic [15:0]        cfg_data     = '0;

  int mismatches;
  int pending;
  int checked;
  int cycle_count = 0;
  int n_set       = 0;
  int n_tick      = 0;
  int n_clear     = 0;
  int n_unused    = 0;
  int n_settings  = 1;

  // 100 MHz clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  spring_animation_table_top i_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .start          (start),
    .busy           (busy),
    .opcode_i       (opcode),
    .slot_i         (slot),
    .target_value_i (target_value),
    .time_step_i    (time_step),
    .result_valid_o (result_valid),
    .slot_out_o     (slot_out),
    .position_out_o (position_out),
    .last_o         (last),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  spring_table_checker i_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .start_i        (start),
    .busy_i         (busy),
    .opcode_i       (opcode),
    .slot_i         (slot),
    .target_value_i (target_value),
    .time_step_i    (time_step),
    .result_valid_i (result_valid),
    .slot_out_i     (slot_out),
    .position_out_i (position_out),
    .last_i         (last),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_i    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .mismatches_o   (mismatches),
    .outstanding_o  (pending),
    .checked_o      (checked)
  );

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d results outstanding",
               $time, cycle_count, pending);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Issue one command word after a gap; returns at the edge that takes it
  task automatic send_word(input logic [1:0] op, input logic [3:0] s,
                           input logic signed [31:0] tgt, input logic [15:0] dt,
                           input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start        <= 1'b1;
    opcode       <= op;
    slot         <= s;
    target_value <= tgt;
    time_step    <= dt;
    do @(posedge clk); while (busy);
    case (op)
      spranim_pkg::OP_SET:   n_set++;
      spranim_pkg::OP_TICK:  n_tick++;
      spranim_pkg::OP_CLEAR: n_clear++;
      default:               n_unused++;
    endcase
  endtask

  // Hold off until every predicted result is in and the block is idle
  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0 || busy) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all three registers back to back while idle
  task automatic load_regs(input logic [15:0] k, input logic [13:0] c, input logic [15:0] thr);
    settle();
    cfg_valid <= 1'b1;
    cfg_index <= spranim_pkg::REG_STIFFNESS;
    cfg_data  <= k;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= spranim_pkg::REG_DAMPING;
    cfg_data  <= {2'b00, c};
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= spranim_pkg::REG_SNAP;
    cfg_data  <= thr;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    n_settings++;
  endtask

  // Half on-screen distances, some near-settled, some wild
  function automatic logic signed [31:0] pick_target();
    int r;
    r = $urandom_range(19);
    if (r < 10) return int'($urandom_range(32'd13107200)) - 6553600;
    if (r < 13) return int'($urandom_range(4000)) - 2000;
    if (r < 17) return $urandom;
    if (r < 18) return 32'sh7FFF_FFFF;
    if (r < 19) return 32'sh8000_0000;
    return 32'sh0;
  endfunction

  // Mostly frame-like tick lengths
  function automatic logic [15:0] pick_step();
    int r;
    r = $urandom_range(9);
    if (r < 6) return 16'($urandom_range(2200, 500));
    if (r < 7) return 16'($urandom_range(100));
    if (r < 8) return $urandom_range(1) ? 16'hFFFF : 16'h0000;
    return 16'($urandom);
  endfunction

  initial begin : stimulus
    int         roll;
    int         gap;
    logic [1:0] op;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty ticks, ignored opcode, extremes, snapping, retarget, clear
    send_word(spranim_pkg::OP_TICK,  4'd0,  32'sh0,         16'd1092, 0);
    send_word(OP_UNUSED,             4'd9,  32'sh1234_5678, 16'd1092, 2);
    send_word(spranim_pkg::OP_SET,   4'd0,  32'sh7FFF_FFFF, 16'd0,    0);
    send_word(spranim_pkg::OP_SET,   4'd15, 32'sh8000_0000, 16'd0,    0);
    send_word(spranim_pkg::OP_SET,   4'd7,  32'sd100,       16'd0,    1);
    send_word(spranim_pkg::OP_TICK,  4'd0,  32'sh0,         16'h0000, 0);
    send_word(spranim_pkg::OP_TICK,  4'd0,  32'sh0,         16'hFFFF, 3);
    send_word(spranim_pkg::OP_TICK,  4'd0,  32'sh0,         16'd1092, 0);
    send_word(spranim_pkg::OP_SET,   4'd0,  -32'sd327680,   16'd0,    0);
    send_word(spranim_pkg::OP_TICK,  4'd0,  32'sh0,         16'd1092, 0);
    send_word(spranim_pkg::OP_SET,   4'd3,  32'shAAAA_5555, 16'd0,    0);
    send_word(spranim_pkg::OP_SET,   4'd12, 32'sh5555_AAAA, 16'd0,    0);
    send_word(spranim_pkg::OP_TICK,  4'd0,  32'sh0,         16'h5555, 5);
    send_word(spranim_pkg::OP_TICK,  4'd0,  32'sh0,         16'hAAAA, 0);
    send_word(spranim_pkg::OP_CLEAR, 4'd0,  32'sh0,         16'd0,    0);
    send_word(spranim_pkg::OP_TICK,  4'd0,  32'sh0,         16'd1092, 0);
    send_word(spranim_pkg::OP_SET,   4'd5,  32'sd196608,    16'd0,    0);
    send_word(spranim_pkg::OP_TICK,  4'd0,  32'sh0,         16'd1092, 11);
    send_word(spranim_pkg::OP_TICK,  4'd0,  32'sh0,         16'd1092, 0);
    send_word(spranim_pkg::OP_TICK,  4'd0,  32'sh0,         16'd1092, 0);

    // Random phases, each under its own register setting
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       load_regs(16'hFFFF, 14'h3FFF, 16'hFFFF);
        1:       load_regs(16'h0000, 14'h0000, 16'h0000);
        2:       load_regs(spranim_pkg::STIFFNESS_RST, spranim_pkg::DAMPING_RST,
                           spranim_pkg::SNAP_RST);
        default: load_regs(16'($urandom), 14'($urandom), 16'($urandom));
      endcase
      for (int n = 0; n < WORDS_PER_PHASE; n++) begin
        // occasional full drain between words
        if ($urandom_range(99) < 4) settle();
        gap  = (p % 3 == 1) ? 0 : $urandom_range(11);
        roll = $urandom_range(99);
        if (roll < 32)      op = spranim_pkg::OP_SET;
        else if (roll < 88) op = spranim_pkg::OP_TICK;
        else if (roll < 94) op = spranim_pkg::OP_CLEAR;
        else                op = OP_UNUSED;
        send_word(op, 4'($urandom_range(15)), pick_target(), pick_step(), gap);
      end
    end

    settle();
    $display("Covered %0d set-target, %0d tick, %0d clear and %0d unused-opcode words",
             n_set, n_tick, n_clear, n_unused);
    $display("under %0d register settings; %0d stepped-slot results compared.",
             n_settings, checked);
    if (pending != 0) $display("%0t: %0d expected results never arrived", $time, pending);
    if (mismatches == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
